@@ src/matrix4x4_inverse_defines.svh @@
// ----------------------------------------------------------------------------
// Matrix inverse assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX4X4_INVERSE_DEFINES_SVH
`define MATRIX4X4_INVERSE_DEFINES_SVH

// condition holds at every edge out of reset
`define M4INV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequence holds in the cycle after the trigger
`define M4INV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) \
    else $error(msg);

`endif

@@ src/m4inv_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix inverse package
// Number format, derived widths, command and status types, cofactor tables.
// ----------------------------------------------------------------------------
package m4inv_pkg;

  localparam int DW    = 32;
  localparam int FB    = 16;
  localparam int THR_W = 17;

  localparam int MW    = 2 * DW + 1;
  localparam int PW    = DW + 1;
  localparam int PRODW = 2 * PW;
  localparam int ACCW  = 2 * MW + 3;
  localparam int DIVW  = ACCW + DW + 2 * FB;
  localparam int QW    = DW - 1;
  localparam int CNTW  = $clog2(DW);
  localparam int ELEMW = 4 * DW;
  localparam int MDEPTH = 12;
  localparam int MAW   = $clog2(MDEPTH);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef enum logic [1:0] {
    MODE_MINOR,
    MODE_DET,
    MODE_COF
  } mode_e;

  typedef struct packed {
    logic           valid;
    mode_e          mode;
    logic           clr;
    logic           neg;
    logic           last;
    logic           a_hi;
    logic           b_hi;
    logic [1:0]     ea_col;
    logic [1:0]     ea_row;
    logic [1:0]     eb_col;
    logic [1:0]     eb_row;
    logic [MAW-1:0] ma_addr;
    logic [MAW-1:0] mb_addr;
    logic [MAW-1:0] wr_addr;
  } op_t;

  typedef struct packed {
    logic       in_wr;
    logic [1:0] in_col;
    logic       div_start;
    logic       emit;
    logic [1:0] emit_col;
  } ctl_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_done;
    logic out_free;
    logic singular;
  } stat_t;

  localparam logic [1:0] PAIR_P [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_Q [6] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
  localparam logic       DET_NEG [6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  localparam logic [3:0] COF_ELEM [16][3] = '{
    '{4'd5, 4'd6, 4'd7},    '{4'd6, 4'd4, 4'd7},
    '{4'd4, 4'd5, 4'd7},    '{4'd5, 4'd4, 4'd6},
    '{4'd2, 4'd1, 4'd3},    '{4'd0, 4'd2, 4'd3},
    '{4'd1, 4'd0, 4'd3},    '{4'd0, 4'd1, 4'd2},
    '{4'd13, 4'd14, 4'd15}, '{4'd14, 4'd12, 4'd15},
    '{4'd12, 4'd13, 4'd15}, '{4'd13, 4'd12, 4'd14},
    '{4'd10, 4'd9, 4'd11},  '{4'd8, 4'd10, 4'd11},
    '{4'd9, 4'd8, 4'd11},   '{4'd8, 4'd9, 4'd10}
  };

  localparam logic [3:0] COF_MINOR [16][3] = '{
    '{4'd11, 4'd10, 4'd9}, '{4'd8, 4'd11, 4'd7},
    '{4'd10, 4'd8, 4'd6},  '{4'd7, 4'd9, 4'd6},
    '{4'd10, 4'd11, 4'd9}, '{4'd11, 4'd8, 4'd7},
    '{4'd8, 4'd10, 4'd6},  '{4'd9, 4'd7, 4'd6},
    '{4'd5, 4'd4, 4'd3},   '{4'd2, 4'd5, 4'd1},
    '{4'd4, 4'd2, 4'd0},   '{4'd1, 4'd3, 4'd0},
    '{4'd4, 4'd5, 4'd3},   '{4'd5, 4'd2, 4'd1},
    '{4'd2, 4'd4, 4'd0},   '{4'd3, 4'd1, 4'd0}
  };

  localparam logic COF_NEG [16][3] = '{
    '{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0}
  };

endpackage

@@ src/m4inv_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module m4inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ src/m4inv_ctrl.sv @@
// ----------------------------------------------------------------------------
// Matrix inverse controller
// Collects columns, sequences minor, determinant and cofactor products,
// starts divisions and emits result columns.
// ----------------------------------------------------------------------------
module m4inv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  m4inv_pkg::stat_t stat_i,
  output m4inv_pkg::op_t  op_o,
  output m4inv_pkg::ctl_t ctl_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MINOR,
    S_DRAIN_M,
    S_DET,
    S_DRAIN_D,
    S_CHECK,
    S_COF,
    S_DRAIN_C,
    S_DIV,
    S_DIV_WAIT,
    S_EMIT,
    S_EMIT_ID
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic [3:0] k_q;
  logic [1:0] col_cnt_q;
  logic [1:0] id_col_q;

  logic       in_accept;
  logic [3:0] m_idx;
  logic [3:0] m_sub;
  logic       m_h;
  logic [2:0] m_k;
  logic [2:0] d_k;
  logic [1:0] c_t;
  logic [3:0] c_e;

  assign in_accept  = (state_q == S_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign m_idx = cnt_q[4:1];
  assign m_sub = m_idx - 4'd6;
  assign m_h   = (m_idx >= 4'd6);
  assign m_k   = m_h ? m_sub[2:0] : m_idx[2:0];
  assign d_k   = cnt_q[4:2];
  assign c_t   = cnt_q[2:1];
  assign c_e   = m4inv_pkg::COF_ELEM[k_q][c_t];

  always_comb begin
    op_o = '0;
    op_o.mode = m4inv_pkg::MODE_MINOR;
    case (state_q)
      S_MINOR: begin
        op_o.valid   = 1'b1;
        op_o.mode    = m4inv_pkg::MODE_MINOR;
        op_o.ea_col  = cnt_q[0] ? m4inv_pkg::PAIR_Q[m_k] : m4inv_pkg::PAIR_P[m_k];
        op_o.eb_col  = cnt_q[0] ? m4inv_pkg::PAIR_P[m_k] : m4inv_pkg::PAIR_Q[m_k];
        op_o.ea_row  = {m_h, 1'b0};
        op_o.eb_row  = {m_h, 1'b1};
        op_o.clr     = !cnt_q[0];
        op_o.neg     = cnt_q[0];
        op_o.last    = cnt_q[0];
        op_o.wr_addr = m_idx;
      end
      S_DET: begin
        op_o.valid   = 1'b1;
        op_o.mode    = m4inv_pkg::MODE_DET;
        op_o.ma_addr = {1'b0, d_k};
        op_o.mb_addr = 4'd11 - {1'b0, d_k};
        op_o.a_hi    = cnt_q[1];
        op_o.b_hi    = cnt_q[0];
        op_o.neg     = m4inv_pkg::DET_NEG[d_k];
        op_o.clr     = (cnt_q == 5'd0);
        op_o.last    = (cnt_q == 5'd23);
      end
      S_COF: begin
        op_o.valid   = 1'b1;
        op_o.mode    = m4inv_pkg::MODE_COF;
        op_o.ea_col  = c_e[1:0];
        op_o.ea_row  = c_e[3:2];
        op_o.mb_addr = m4inv_pkg::COF_MINOR[k_q][c_t];
        op_o.b_hi    = cnt_q[0];
        op_o.neg     = m4inv_pkg::COF_NEG[k_q][c_t];
        op_o.clr     = (cnt_q == 5'd0);
        op_o.last    = (cnt_q == 5'd5);
      end
      default: begin
        op_o.valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.in_wr     = in_accept;
    ctl_o.in_col    = col_cnt_q;
    ctl_o.div_start = (state_q == S_DIV);
    ctl_o.emit      = ((state_q == S_EMIT) || (state_q == S_EMIT_ID)) && stat_i.out_free;
    ctl_o.emit_col  = (state_q == S_EMIT_ID) ? id_col_q : k_q[3:2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      k_q       <= '0;
      col_cnt_q <= '0;
      id_col_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            col_cnt_q <= col_cnt_q + 2'd1;
            if (col_cnt_q == 2'd3) begin
              state_q <= S_MINOR;
              cnt_q   <= '0;
            end
          end
        end
        S_MINOR: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd23) begin
            state_q <= S_DRAIN_M;
          end
        end
        S_DRAIN_M: begin
          if (!stat_i.pipe_busy) begin
            state_q <= S_DET;
            cnt_q   <= '0;
          end
        end
        S_DET: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd23) begin
            state_q <= S_DRAIN_D;
          end
        end
        S_DRAIN_D: begin
          if (!stat_i.pipe_busy) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt_q    <= '0;
          k_q      <= '0;
          id_col_q <= '0;
          state_q  <= stat_i.singular ? S_EMIT_ID : S_COF;
        end
        S_COF: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd5) begin
            state_q <= S_DRAIN_C;
          end
        end
        S_DRAIN_C: begin
          if (!stat_i.pipe_busy) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (stat_i.div_done) begin
            if (k_q[1:0] == 2'd3) begin
              state_q <= S_EMIT;
            end else begin
              k_q     <= k_q + 4'd1;
              cnt_q   <= '0;
              state_q <= S_COF;
            end
          end
        end
        S_EMIT: begin
          if (stat_i.out_free) begin
            if (k_q == 4'd15) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 4'd1;
              cnt_q   <= '0;
              state_q <= S_COF;
            end
          end
        end
        S_EMIT_ID: begin
          if (stat_i.out_free) begin
            id_col_q <= id_col_q + 2'd1;
            if (id_col_q == 2'd3) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/m4inv_dp.sv @@
// ----------------------------------------------------------------------------
// Matrix inverse datapath
// Column and minor stores, shared multiply-accumulate, restoring divider,
// threshold register and output register.
// ----------------------------------------------------------------------------
`include "matrix4x4_inverse_defines.svh"

module m4inv_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [m4inv_pkg::DW-1:0] row0_value_i,
  input  logic signed [m4inv_pkg::DW-1:0] row1_value_i,
  input  logic signed [m4inv_pkg::DW-1:0] row2_value_i,
  input  logic signed [m4inv_pkg::DW-1:0] row3_value_i,
  input  m4inv_pkg::op_t                op_i,
  input  m4inv_pkg::ctl_t               ctl_i,
  input  logic                          cfg_valid_i,
  input  logic [m4inv_pkg::THR_W-1:0]   cfg_data_i,
  output m4inv_pkg::stat_t              stat_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    column_index_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row0_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row1_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row2_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row3_o,
  output logic                          singular_o,
  output logic                          last_column_o
);

  localparam int DW    = m4inv_pkg::DW;
  localparam int FB    = m4inv_pkg::FB;
  localparam int MW    = m4inv_pkg::MW;
  localparam int PW    = m4inv_pkg::PW;
  localparam int PRODW = m4inv_pkg::PRODW;
  localparam int ACCW  = m4inv_pkg::ACCW;
  localparam int DIVW  = m4inv_pkg::DIVW;
  localparam int QW    = m4inv_pkg::QW;
  localparam int CNTW  = m4inv_pkg::CNTW;
  localparam int THR_W = m4inv_pkg::THR_W;

  logic [m4inv_pkg::ELEMW-1:0] ea_data, eb_data;
  logic [MW-1:0]               ma_data, mb_data;

  m4inv_pkg::op_t op1_q, op2_q;

  logic [DW-1:0]          ea_elem, eb_elem;
  logic signed [PW-1:0]   opa, opb;
  logic signed [PRODW-1:0] prod_q;
  logic [ACCW-1:0]        term, base, acc_d, acc_q, det_q;
  logic                   minor_we, det_we;

  logic [THR_W-1:0]       thr_q;
  logic signed [ACCW-1:0] thr_big, thr_neg;
  logic                   sing;

  logic [ACCW-1:0]        abs_acc, abs_det;
  logic [DIVW-1:0]        rem_q, dsh_q;
  logic [QW-1:0]          q_q, q_d;
  logic [CNTW-1:0]        div_cnt_q;
  logic                   div_busy_q, div_done_q, dneg_q;
  logic                   ge, div_fin, div_sat;
  logic [DW-1:0]          q_ext, div_res;
  logic [DW-1:0]          col_q [4];

  logic                   out_valid_q, out_free;
  logic [DW-1:0]          out_row_q [4];
  logic [1:0]             out_col_q;
  logic                   out_sing_q, out_last_q;

  m4inv_ram #(.WIDTH(m4inv_pkg::ELEMW), .DEPTH(4)) u_elem_ram (
    .clk_i     (clk_i),
    .we_i      (ctl_i.in_wr),
    .waddr_i   (ctl_i.in_col),
    .wdata_i   ({row3_value_i, row2_value_i, row1_value_i, row0_value_i}),
    .raddr_a_i (op_i.ea_col),
    .rdata_a_o (ea_data),
    .raddr_b_i (op_i.eb_col),
    .rdata_b_o (eb_data)
  );

  m4inv_ram #(.WIDTH(MW), .DEPTH(m4inv_pkg::MDEPTH)) u_minor_ram (
    .clk_i     (clk_i),
    .we_i      (minor_we),
    .waddr_i   (op2_q.wr_addr),
    .wdata_i   (acc_d[MW-1:0]),
    .raddr_a_i (op_i.ma_addr),
    .rdata_a_o (ma_data),
    .raddr_b_i (op_i.mb_addr),
    .rdata_b_o (mb_data)
  );

  assign ea_elem = ea_data[op1_q.ea_row*DW +: DW];
  assign eb_elem = eb_data[op1_q.eb_row*DW +: DW];

  always_comb begin
    opa = '0;
    opb = '0;
    case (op1_q.mode)
      m4inv_pkg::MODE_MINOR: begin
        opa = {ea_elem[DW-1], ea_elem};
        opb = {eb_elem[DW-1], eb_elem};
      end
      m4inv_pkg::MODE_DET: begin
        opa = op1_q.a_hi ? ma_data[MW-1:DW] : {1'b0, ma_data[DW-1:0]};
        opb = op1_q.b_hi ? mb_data[MW-1:DW] : {1'b0, mb_data[DW-1:0]};
      end
      m4inv_pkg::MODE_COF: begin
        opa = {ea_elem[DW-1], ea_elem};
        opb = op1_q.b_hi ? mb_data[MW-1:DW] : {1'b0, mb_data[DW-1:0]};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    term = {{(ACCW-PRODW){prod_q[PRODW-1]}}, prod_q};
    case ({op2_q.a_hi, op2_q.b_hi})
      2'b00:   term = term;
      2'b01:   term = term << DW;
      2'b10:   term = term << DW;
      2'b11:   term = term << (2 * DW);
      default: term = term;
    endcase
  end

  assign base     = op2_q.clr ? '0 : acc_q;
  assign acc_d    = base + (term ^ {ACCW{op2_q.neg}}) + ACCW'(op2_q.neg);
  assign minor_we = op2_q.valid && op2_q.last && (op2_q.mode == m4inv_pkg::MODE_MINOR);
  assign det_we   = op2_q.valid && op2_q.last && (op2_q.mode == m4inv_pkg::MODE_DET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q <= '0;
      op2_q <= '0;
    end else begin
      op1_q <= op_i;
      op2_q <= op1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
    if (op2_q.valid) begin
      acc_q <= acc_d;
    end
    if (det_we) begin
      det_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= m4inv_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign thr_big = {{(ACCW-THR_W-3*FB){1'b0}}, thr_q, {(3*FB){1'b0}}};
  assign thr_neg = -thr_big;
  assign sing    = ($signed(det_q) < thr_big) && ($signed(det_q) > thr_neg);

  assign abs_acc = acc_q[ACCW-1] ? (~acc_q + ACCW'(1)) : acc_q;
  assign abs_det = det_q[ACCW-1] ? (~det_q + ACCW'(1)) : det_q;

  assign ge      = (rem_q >= dsh_q);
  assign div_sat = (div_cnt_q == CNTW'(DW - 1)) && ge;
  assign div_fin = div_busy_q && (div_sat || (div_cnt_q == '0));
  assign q_d     = (ge && (div_cnt_q != CNTW'(DW - 1))) ?
                   (q_q | (QW'(1) << div_cnt_q)) : q_q;
  assign q_ext   = {1'b0, q_d};

  always_comb begin
    if (div_sat) begin
      div_res = dneg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      div_res = dneg_q ? (~q_ext + DW'(1)) : q_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
    end else begin
      div_done_q <= div_fin;
      if (ctl_i.div_start) begin
        div_busy_q <= 1'b1;
      end else if (div_fin) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      rem_q     <= DIVW'(abs_acc) << (2 * FB);
      dsh_q     <= DIVW'(abs_det) << (DW - 1);
      dneg_q    <= (acc_q[ACCW-1] ^ det_q[ACCW-1]) && (|det_q);
      q_q       <= '0;
      div_cnt_q <= CNTW'(DW - 1);
    end else if (div_busy_q) begin
      if (ge && !div_sat) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q     <= dsh_q >> 1;
      q_q       <= q_d;
      div_cnt_q <= div_cnt_q - CNTW'(1);
    end
    if (div_fin) begin
      col_q[0] <= col_q[1];
      col_q[1] <= col_q[2];
      col_q[2] <= col_q[3];
      col_q[3] <= div_res;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_col_q  <= ctl_i.emit_col;
      out_sing_q <= sing;
      out_last_q <= (ctl_i.emit_col == 2'd3);
      for (int r = 0; r < 4; r++) begin
        if (sing) begin
          out_row_q[r] <= (ctl_i.emit_col == 2'(r)) ? (DW'(1) << FB) : '0;
        end else begin
          out_row_q[r] <= col_q[r];
        end
      end
    end
  end

  assign stat_o.pipe_busy = op1_q.valid || op2_q.valid;
  assign stat_o.div_done  = div_done_q;
  assign stat_o.out_free  = out_free;
  assign stat_o.singular  = sing;

  assign out_valid_o    = out_valid_q;
  assign column_index_o = out_col_q;
  assign out_row0_o     = out_row_q[0];
  assign out_row1_o     = out_row_q[1];
  assign out_row2_o     = out_row_q[2];
  assign out_row3_o     = out_row_q[3];
  assign singular_o     = out_sing_q;
  assign last_column_o  = out_last_q;

  `M4INV_ASSERT(a_emit_free, ctl_i.emit |-> (!out_valid_q || !out_stall_i), "emit onto held item")
  `M4INV_ASSERT(a_start_quiet, ctl_i.div_start |-> (!div_busy_q && !op1_q.valid && !op2_q.valid), "divide started early")
  `M4INV_ASSERT(a_no_op_in_div, op_i.valid |-> !div_busy_q, "product issued during divide")
  `M4INV_ASSERT_NEXT(a_emit_shows, ctl_i.emit, out_valid_q, "emitted column not shown")

endmodule

@@ src/matrix4x4_inverse.sv @@
// For a singular matrix the identity columns follow the determinant directly; otherwise
// the 16 cofactors are formed in turn, each from 6 products, drained and then divided by
// the determinant, the divide ending early if it saturates.
// Throughput: one matrix at a time; the input stalls until the last result leaves.
// Reset: rst_ni, asynchronous, clears the column count, control and threshold (1).
// ----------------------------------------------------------------------------
// Matrix inverse top level
// 4x4 fixed-point inverse by cofactors, controller plus datapath.
// ----------------------------------------------------------------------------
module matrix4x4_inverse (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [m4inv_pkg::DW-1:0] row0_value_i,
  input  logic signed [m4inv_pkg::DW-1:0] row1_value_i,
  input  logic signed [m4inv_pkg::DW-1:0] row2_value_i,
  input  logic signed [m4inv_pkg::DW-1:0] row3_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      column_index_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row0_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row1_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row2_o,
  output logic signed [m4inv_pkg::DW-1:0] out_row3_o,
  output logic                            singular_o,
  output logic                            last_column_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [m4inv_pkg::THR_W-1:0]     singular_threshold_i
);

  m4inv_pkg::op_t   op;
  m4inv_pkg::ctl_t  ctl;
  m4inv_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  m4inv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .op_o       (op),
    .ctl_o      (ctl)
  );

  m4inv_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row0_value_i   (row0_value_i),
    .row1_value_i   (row1_value_i),
    .row2_value_i   (row2_value_i),
    .row3_value_i   (row3_value_i),
    .op_i           (op),
    .ctl_i          (ctl),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (singular_threshold_i),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_index_o (column_index_o),
    .out_row0_o     (out_row0_o),
    .out_row1_o     (out_row1_o),
    .out_row2_o     (out_row2_o),
    .out_row3_o     (out_row3_o),
    .singular_o     (singular_o),
    .last_column_o  (last_column_o)
  );

endmodule
